// ----- design/tsched_pkg.sv -----
// shared types and constants of the thread scheduler
`default_nettype none
package tsched_pkg;
    // default table sizes
    localparam int unsigned MAX_THREADS_DEF = 16;
    localparam int unsigned MAX_WAITING_DEF = 16;

    // field widths
    localparam int unsigned ID_W       = 16;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned BUD_W      = 18;
    localparam int unsigned QNT_W      = 10;
    localparam int unsigned TICK_W     = 8;
    localparam int unsigned POL_W      = 3;
    localparam int unsigned RR_W       = 4;
    localparam int unsigned CMD_W      = 3;
    localparam int unsigned KIND_W     = 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;

    // commands
    localparam logic [CMD_W-1:0] CMD_REGISTER = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_EXPIRE   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_YIELD    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FINISH   = 3'd4;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_DISPATCH = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EXIT     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE     = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FULL     = 2'd3;

    // policies
    localparam logic [POL_W-1:0] POL_RING = 3'd0;
    localparam logic [POL_W-1:0] POL_RR   = 3'd1;
    localparam logic [POL_W-1:0] POL_FCFS = 3'd2;
    localparam logic [POL_W-1:0] POL_SJF  = 3'd3;
    localparam logic [POL_W-1:0] POL_PSJF = 3'd4;

    // configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RR      = 2'd2;
    localparam logic [POL_W-1:0]     POLICY_RST  = 3'd0;
    localparam logic [TICK_W-1:0]    QUANTUM_RST = 8'd5;
    localparam logic [RR_W-1:0]      RR_RST      = 4'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_FULL, S_CHARGE, S_REL_INIT, S_REL_FIND, S_REL_ENTER, S_AFTER_REL,
        S_EXIT, S_SHORT_INIT, S_SHORT, S_SHORT_END, S_UNLINK, S_DISP, S_DONE
    } t_state;

    typedef enum logic [1:0] {A_START, A_CONT, A_EXIT} t_after;
    typedef enum logic {T_DISP, T_UNLINK} t_then;
endpackage
`default_nettype wire

// ----- design/tsched_if.sv -----
// request and result channels of the thread scheduler
`default_nettype none
interface tsched_in_if import tsched_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [QNT_W-1:0]  work_quanta;
    logic [TIME_W-1:0] release_time;
    logic [TICK_W-1:0] ticks_used;
    modport source (output valid, command, work_quanta, release_time, ticks_used,
                    input ready);
    modport sink (input valid, command, work_quanta, release_time, ticks_used,
                  output ready);
endinterface

interface tsched_out_if import tsched_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   thread_number;
    logic [TICK_W-1:0] slice;
    logic [TIME_W-1:0] elapsed;
    logic              last;
    modport source (output valid, kind, thread_number, slice, elapsed, last, input ready);
    modport sink (input valid, kind, thread_number, slice, elapsed, last, output ready);
endinterface
`default_nettype wire

// ----- design/tsched_alu.sv -----
// shared subtract and compare unit
`default_nettype none
module tsched_alu import tsched_pkg::*; (
    input  wire logic [TIME_W-1:0] i_a,
    input  wire logic [TIME_W-1:0] i_b,
    output logic      [TIME_W-1:0] o_diff,
    output logic                   o_lt
);
    // borrow out flags a below b
    assign {o_lt, o_diff} = {1'b0, i_a} - {1'b0, i_b};
endmodule
`default_nettype wire

// ----- design/thread_scheduler_multi_policy.sv -----
// top level of the multi-policy thread scheduler
`default_nettype none
// Thread scheduler with a waiting table and a ring of runnable threads, both in
// flip-flops, driven by a small sequencer around one shared 32-bit subtractor.
// A register request completes in the idle state unless the table is full. Start,
// expiry, yield and finish requests run the release scan, which finds each
// waiting position in registration order and moves each due thread into the
// ring, and may run a shortest-first search over all ring slots. The request
// side is ready only when the sequencer is idle; one output register holds a
// result until taken, so a new request can be taken while the last result
// still waits.
module thread_scheduler_multi_policy import tsched_pkg::*; #(
    parameter int unsigned MAX_THREADS = MAX_THREADS_DEF,
    parameter int unsigned MAX_WAITING = MAX_WAITING_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    tsched_in_if.sink                  i_req,
    tsched_out_if.source               o_rsp
);
    localparam int unsigned TW = $clog2(MAX_THREADS);
    localparam int unsigned WW = (MAX_WAITING > 1) ? $clog2(MAX_WAITING) : 1;
    localparam int unsigned CW = $clog2(MAX_WAITING + 1);

    // configuration
    logic [POL_W-1:0]  r_pol;
    logic [TICK_W-1:0] r_qnt;
    logic [RR_W-1:0]   r_rrs;

    // run ring
    logic [MAX_THREADS-1:0] r_rv;
    logic [ID_W-1:0]   r_rid  [MAX_THREADS];
    logic [BUD_W-1:0]  r_rbud [MAX_THREADS];
    logic [TIME_W-1:0] r_rent [MAX_THREADS];
    logic [TW-1:0]     r_rnx  [MAX_THREADS];
    logic [TW-1:0]     r_rpv  [MAX_THREADS];

    // waiting table
    logic [MAX_WAITING-1:0] r_wv;
    logic [QNT_W-1:0]  r_wbud [MAX_WAITING];
    logic [TIME_W-1:0] r_wrel [MAX_WAITING];
    logic [WW-1:0]     r_word [MAX_WAITING];

    // sequencer state
    t_state r_state, n_state;
    t_after r_after, n_after;
    t_then  r_then, n_then;
    logic [CMD_W-1:0]  r_cmd, n_cmd;
    logic [TICK_W-1:0] r_ticks, n_ticks;
    logic [WW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_pos, n_pos;
    logic [CW-1:0]     r_wcnt, n_wcnt;
    logic [TW-1:0]     r_sidx, n_sidx;
    logic [TW-1:0]     r_best, n_best;
    logic              r_best_ok, n_best_ok;
    logic [BUD_W-1:0]  r_bbud, n_bbud;
    logic [ID_W-1:0]   r_bid, n_bid;
    logic              r_skip, n_skip;
    logic [TW-1:0]     r_cur, n_cur;
    logic [TW-1:0]     r_old, n_old;
    logic [TIME_W-1:0] r_sys, n_sys;
    logic [ID_W-1:0]   r_idc, n_idc;
    logic              r_started, n_started;
    logic [RR_W-1:0]   r_rr, n_rr;

    // output register
    logic              r_ov, n_ov;
    logic [KIND_W-1:0] r_okind, n_okind;
    logic [ID_W-1:0]   r_oid, n_oid;
    logic [TICK_W-1:0] r_osl, n_osl;
    logic [TIME_W-1:0] r_oel, n_oel;
    logic              r_olast, n_olast;

    // read ports
    logic [TW-1:0]     run_addr;
    logic              rd_v;
    logic [ID_W-1:0]   rd_id;
    logic [BUD_W-1:0]  rd_bud;
    logic [TIME_W-1:0] rd_ent;
    logic [TW-1:0]     rd_nx, rd_pv;
    logic              wd_v;
    logic [QNT_W-1:0]  wd_bud;
    logic [TIME_W-1:0] wd_rel;
    logic [WW-1:0]     wd_ord;

    // free slot search
    logic          free_run_ok, free_w_ok;
    logic [TW-1:0] free_run;
    logic [WW-1:0] free_w;

    // shared unit
    logic [TIME_W-1:0] alu_a, alu_b, alu_d;
    logic              alu_lt;

    // write strobes
    logic              w_reg, w_rel, ins, unl, rv_clr, bud_we;
    logic [BUD_W-1:0]  bud_d;
    logic [BUD_W-1:0]  new_bud;
    logic              in_acc, out_free, yielded, cand, better;

    tsched_alu u_alu (
        .i_a    (alu_a),
        .i_b    (alu_b),
        .o_diff (alu_d),
        .o_lt   (alu_lt)
    );

    assign in_acc      = i_req.valid && (r_state == S_IDLE);
    assign i_req.ready = (r_state == S_IDLE);
    assign out_free    = !r_ov || o_rsp.ready;
    assign yielded     = (r_cmd == CMD_YIELD);
    assign new_bud     = BUD_W'(wd_bud) * BUD_W'(r_qnt);

    assign o_rsp.valid         = r_ov;
    assign o_rsp.kind          = r_okind;
    assign o_rsp.thread_number = r_oid;
    assign o_rsp.slice         = r_osl;
    assign o_rsp.elapsed       = r_oel;
    assign o_rsp.last          = r_olast;

    // ring read address
    always_comb begin
        case (r_state)
            S_SHORT:  run_addr = r_sidx;
            S_UNLINK: run_addr = r_old;
            default:  run_addr = r_cur;
        endcase
    end

    assign rd_v   = r_rv[run_addr];
    assign rd_id  = r_rid[run_addr];
    assign rd_bud = r_rbud[run_addr];
    assign rd_ent = r_rent[run_addr];
    assign rd_nx  = r_rnx[run_addr];
    assign rd_pv  = r_rpv[run_addr];
    assign wd_v   = r_wv[r_idx];
    assign wd_bud = r_wbud[r_idx];
    assign wd_rel = r_wrel[r_idx];
    assign wd_ord = r_word[r_idx];

    // lowest free slots
    always_comb begin
        free_run_ok = 1'b0;
        free_run    = '0;
        for (int i = MAX_THREADS - 1; i >= 0; i--) begin
            if (!r_rv[i]) begin
                free_run_ok = 1'b1;
                free_run    = TW'(i);
            end
        end
        free_w_ok = 1'b0;
        free_w    = '0;
        for (int i = MAX_WAITING - 1; i >= 0; i--) begin
            if (!r_wv[i]) begin
                free_w_ok = 1'b1;
                free_w    = WW'(i);
            end
        end
    end

    // shared unit operands
    always_comb begin
        case (r_state)
            S_REL_FIND: begin
                alu_a = r_sys;
                alu_b = wd_rel;
            end
            S_CHARGE: begin
                alu_a = TIME_W'(rd_bud);
                alu_b = TIME_W'(r_ticks);
            end
            S_SHORT: begin
                alu_a = TIME_W'(rd_bud);
                alu_b = TIME_W'(r_bbud);
            end
            S_DISP: begin
                alu_a = TIME_W'(rd_bud);
                alu_b = TIME_W'(r_qnt);
            end
            default: begin
                alu_a = r_sys;
                alu_b = rd_ent;
            end
        endcase
    end

    assign cand   = rd_v && !(r_skip && (r_sidx == r_cur));
    assign better = !r_best_ok || alu_lt || ((alu_d == '0) && (rd_id < r_bid));

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_after   = r_after;
        n_then    = r_then;
        n_cmd     = r_cmd;
        n_ticks   = r_ticks;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_wcnt    = r_wcnt;
        n_sidx    = r_sidx;
        n_best    = r_best;
        n_best_ok = r_best_ok;
        n_bbud    = r_bbud;
        n_bid     = r_bid;
        n_skip    = r_skip;
        n_cur     = r_cur;
        n_old     = r_old;
        n_sys     = r_sys;
        n_idc     = r_idc;
        n_started = r_started;
        n_rr      = r_rr;
        n_ov      = r_ov && !o_rsp.ready;
        n_okind   = r_okind;
        n_oid     = r_oid;
        n_osl     = r_osl;
        n_oel     = r_oel;
        n_olast   = r_olast;
        w_reg     = 1'b0;
        w_rel     = 1'b0;
        ins       = 1'b0;
        unl       = 1'b0;
        rv_clr    = 1'b0;
        bud_we    = 1'b0;
        bud_d     = '0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_cmd   = i_req.command;
                    n_ticks = i_req.ticks_used;
                    case (i_req.command)
                        CMD_REGISTER: begin
                            if (!free_w_ok) begin
                                n_state = S_FULL;
                            end else begin
                                w_reg  = 1'b1;
                                n_wcnt = r_wcnt + 1'b1;
                            end
                        end
                        CMD_START: begin
                            if (!r_started) begin
                                n_after = A_START;
                                n_state = S_REL_INIT;
                            end
                        end
                        CMD_EXPIRE, CMD_YIELD: begin
                            if (r_started && rd_v) begin
                                n_state = S_CHARGE;
                            end
                        end
                        CMD_FINISH: begin
                            if (r_started && rd_v) begin
                                n_sys   = r_sys + TIME_W'(i_req.ticks_used);
                                n_after = A_EXIT;
                                n_state = S_REL_INIT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_FULL: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_okind = KIND_FULL;
                    n_oid   = '0;
                    n_osl   = '0;
                    n_oel   = '0;
                    n_olast = 1'b1;
                    n_state = S_IDLE;
                end
            end
            // charge ticks, saturating at zero
            S_CHARGE: begin
                bud_we = 1'b1;
                bud_d  = (!alu_lt && (alu_d != '0)) ? alu_d[BUD_W-1:0] : '0;
                n_sys  = r_sys + TIME_W'(r_ticks);
                n_after = (bud_d != '0) ? A_CONT : A_EXIT;
                n_state = S_REL_INIT;
            end
            S_REL_INIT: begin
                n_pos   = '0;
                n_idx   = '0;
                n_state = S_REL_FIND;
            end
            // find the waiting entry at the current position
            S_REL_FIND: begin
                if (r_pos >= r_wcnt) begin
                    n_state = S_AFTER_REL;
                end else if (wd_v && (wd_ord == r_pos[WW-1:0])) begin
                    if (alu_lt) begin
                        n_pos = r_pos + 1'b1;
                        n_idx = '0;
                    end else if (!free_run_ok) begin
                        n_state = S_AFTER_REL;
                    end else begin
                        n_state = S_REL_ENTER;
                    end
                end else begin
                    n_idx = (r_idx == WW'(MAX_WAITING - 1)) ? '0 : r_idx + 1'b1;
                end
            end
            // move the entry into the ring just before the current thread
            S_REL_ENTER: begin
                ins    = 1'b1;
                w_rel  = 1'b1;
                n_wcnt = r_wcnt - 1'b1;
                n_idc  = r_idc + 1'b1;
                n_idx  = '0;
                if (!rd_v) begin
                    n_cur = free_run;
                end
                n_state = S_REL_FIND;
            end
            S_AFTER_REL: begin
                case (r_after)
                    A_START: begin
                        if (!rd_v) begin
                            n_state = S_DONE;
                        end else begin
                            n_started = 1'b1;
                            if (r_pol == POL_SJF || r_pol == POL_PSJF) begin
                                n_skip  = 1'b0;
                                n_then  = T_DISP;
                                n_state = S_SHORT_INIT;
                            end else begin
                                n_state = S_DISP;
                            end
                        end
                    end
                    A_CONT: begin
                        n_state = S_DISP;
                        case (r_pol)
                            POL_RR: begin
                                if (yielded || (r_rr >= r_rrs)) begin
                                    n_cur = rd_nx;
                                    n_rr  = RR_W'(1);
                                end else begin
                                    n_rr = r_rr + 1'b1;
                                end
                            end
                            POL_FCFS: ;
                            POL_SJF: begin
                                if (yielded) begin
                                    n_skip  = 1'b0;
                                    n_then  = T_DISP;
                                    n_state = S_SHORT_INIT;
                                end
                            end
                            POL_PSJF: begin
                                n_skip  = 1'b0;
                                n_then  = T_DISP;
                                n_state = S_SHORT_INIT;
                            end
                            default: n_cur = rd_nx;
                        endcase
                    end
                    default: n_state = S_EXIT;
                endcase
            end
            // exit report, then pick the successor
            S_EXIT: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_okind = KIND_EXIT;
                    n_oid   = rd_id;
                    n_osl   = '0;
                    n_oel   = alu_d;
                    n_olast = 1'b0;
                    n_old   = r_cur;
                    if (rd_nx == r_cur) begin
                        rv_clr    = 1'b1;
                        n_started = 1'b0;
                        n_state   = S_DONE;
                    end else begin
                        case (r_pol)
                            POL_RR: begin
                                n_rr    = RR_W'(1);
                                n_cur   = rd_nx;
                                n_state = S_UNLINK;
                            end
                            POL_SJF, POL_PSJF: begin
                                n_skip  = 1'b1;
                                n_then  = T_UNLINK;
                                n_state = S_SHORT_INIT;
                            end
                            default: begin
                                n_cur   = rd_nx;
                                n_state = S_UNLINK;
                            end
                        endcase
                    end
                end
            end
            S_SHORT_INIT: begin
                n_sidx    = '0;
                n_best_ok = 1'b0;
                n_state   = S_SHORT;
            end
            // shortest remaining budget, lower id on ties
            S_SHORT: begin
                if (cand && better) begin
                    n_best    = r_sidx;
                    n_best_ok = 1'b1;
                    n_bbud    = rd_bud;
                    n_bid     = rd_id;
                end
                if (r_sidx == TW'(MAX_THREADS - 1)) begin
                    n_state = S_SHORT_END;
                end else begin
                    n_sidx = r_sidx + 1'b1;
                end
            end
            S_SHORT_END: begin
                if (r_best_ok) begin
                    n_cur = r_best;
                end
                n_state = (r_then == T_DISP) ? S_DISP : S_UNLINK;
            end
            S_UNLINK: begin
                unl     = 1'b1;
                rv_clr  = 1'b1;
                n_state = S_DISP;
            end
            S_DISP: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_okind = KIND_DISPATCH;
                    n_oid   = rd_id;
                    n_osl   = alu_lt ? rd_bud[TICK_W-1:0] : r_qnt;
                    n_oel   = '0;
                    n_olast = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_okind = KIND_DONE;
                    n_oid   = '0;
                    n_osl   = '0;
                    n_oel   = '0;
                    n_olast = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_after   <= A_START;
            r_then    <= T_DISP;
            r_idx     <= '0;
            r_pos     <= '0;
            r_wcnt    <= '0;
            r_sidx    <= '0;
            r_best_ok <= 1'b0;
            r_skip    <= 1'b0;
            r_cur     <= '0;
            r_old     <= '0;
            r_sys     <= '0;
            r_idc     <= ID_W'(1);
            r_started <= 1'b0;
            r_rr      <= RR_W'(1);
            r_ov      <= 1'b0;
            r_pol     <= POLICY_RST;
            r_qnt     <= QUANTUM_RST;
            r_rrs     <= RR_RST;
        end else begin
            r_state   <= n_state;
            r_after   <= n_after;
            r_then    <= n_then;
            r_idx     <= n_idx;
            r_pos     <= n_pos;
            r_wcnt    <= n_wcnt;
            r_sidx    <= n_sidx;
            r_best_ok <= n_best_ok;
            r_skip    <= n_skip;
            r_cur     <= n_cur;
            r_old     <= n_old;
            r_sys     <= n_sys;
            r_idc     <= n_idc;
            r_started <= n_started;
            r_rr      <= n_rr;
            r_ov      <= n_ov;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_POLICY:  r_pol <= i_cfg_data[POL_W-1:0];
                    CFG_QUANTUM: r_qnt <= i_cfg_data[TICK_W-1:0];
                    CFG_RR:      r_rrs <= i_cfg_data[RR_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_ticks <= n_ticks;
        r_best  <= n_best;
        r_bbud  <= n_bbud;
        r_bid   <= n_bid;
        r_okind <= n_okind;
        r_oid   <= n_oid;
        r_osl   <= n_osl;
        r_oel   <= n_oel;
        r_olast <= n_olast;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv <= '0;
            r_wv <= '0;
        end else begin
            if (ins) begin
                r_rv[free_run] <= 1'b1;
            end
            if (rv_clr) begin
                r_rv[run_addr] <= 1'b0;
            end
            if (w_reg) begin
                r_wv[free_w] <= 1'b1;
            end
            if (w_rel) begin
                r_wv[r_idx] <= 1'b0;
            end
        end
    end

    // ring tables
    always_ff @(posedge i_clk) begin
        if (bud_we) begin
            r_rbud[r_cur] <= bud_d;
        end
        if (ins) begin
            r_rid[free_run]  <= r_idc;
            r_rbud[free_run] <= new_bud;
            r_rent[free_run] <= r_sys;
            if (!rd_v) begin
                r_rnx[free_run] <= free_run;
                r_rpv[free_run] <= free_run;
            end else begin
                r_rnx[rd_pv]    <= free_run;
                r_rpv[r_cur]    <= free_run;
                r_rnx[free_run] <= r_cur;
                r_rpv[free_run] <= rd_pv;
            end
        end
        if (unl) begin
            r_rnx[rd_pv] <= rd_nx;
            r_rpv[rd_nx] <= rd_pv;
        end
    end

    // waiting tables, orders kept compact on release
    always_ff @(posedge i_clk) begin
        if (w_reg) begin
            r_wbud[free_w] <= i_req.work_quanta;
            r_wrel[free_w] <= i_req.release_time;
            r_word[free_w] <= r_wcnt[WW-1:0];
        end
        if (w_rel) begin
            for (int w = 0; w < MAX_WAITING; w++) begin
                if (r_wv[w] && (r_word[w] > r_pos[WW-1:0])) begin
                    r_word[w] <= r_word[w] - 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ----- tb/thread_scheduler_multi_policy_tb.sv -----
// self-checking testbench of the multi-policy thread scheduler
`default_nettype none
module thread_scheduler_multi_policy_tb;
    import tsched_pkg::*;

    localparam int NT = 16;
    localparam int NW = 16;
    localparam int STALL_LIMIT = 6000;
    localparam int SETTLE = 150;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   num;
        logic [TICK_W-1:0] slice;
        logic [TIME_W-1:0] elapsed;
        logic              last;
    } t_sched_event;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    tsched_in_if req_if ();
    tsched_out_if rsp_if ();

    thread_scheduler_multi_policy uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_req(req_if), .o_rsp(rsp_if)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // scheduler shadow state
    logic [POL_W-1:0]  pol_q;
    logic [TICK_W-1:0] quant_q;
    logic [RR_W-1:0]   rr_q;
    logic              rv [NT];
    logic [ID_W-1:0]   rid [NT];
    logic [BUD_W-1:0]  rbud [NT];
    logic [TIME_W-1:0] rent [NT];
    logic [3:0]        rnext [NT];
    logic              wv [NW];
    logic [QNT_W-1:0]  wbud [NW];
    logic [TIME_W-1:0] wrel [NW];
    logic [15:0]       word [NW];
    logic [3:0]        cur;
    logic [TIME_W-1:0] now_ticks;
    logic [ID_W-1:0]   next_id;
    logic              running;
    logic [RR_W-1:0]   rr_cnt;

    t_sched_event expected_events[$];
    int errors = 0;
    int idle_cycles = 0;
    bit hold_off = 0;

    function automatic logic [3:0] ring_pred(logic [3:0] s);
        for (int i = 0; i < NT; i++)
            if (rv[i] && rnext[i] == s) return 4'(i);
        return s;
    endfunction

    function automatic bit enter_ring(int w);
        int r;
        logic [3:0] p;
        r = NT;
        for (int i = NT - 1; i >= 0; i--)
            if (!rv[i]) r = i;
        if (r >= NT) return 0;
        rv[r] = 1'b1;
        rid[r] = next_id;
        next_id = next_id + 1'b1;
        rbud[r] = BUD_W'(wbud[w]) * BUD_W'(quant_q);
        rent[r] = now_ticks;
        if (!rv[cur]) begin
            cur = 4'(r);
            rnext[r] = 4'(r);
        end else begin
            p = ring_pred(cur);
            rnext[p] = 4'(r);
            rnext[r] = cur;
        end
        return 1;
    endfunction

    function automatic void release_due();
        int w;
        logic [15:0] rank [NW];
        for (int pos = 0; pos < NW; pos++) begin
            w = NW;
            for (int i = NW - 1; i >= 0; i--)
                if (wv[i] && word[i] == 16'(pos)) w = i;
            if (w >= NW || now_ticks < wrel[w]) continue;
            if (!enter_ring(w)) break;
            wv[w] = 1'b0;
        end
        for (int i = 0; i < NW; i++) begin
            rank[i] = 0;
            for (int j = 0; j < NW; j++)
                if (wv[i] && wv[j] && word[j] < word[i]) rank[i]++;
        end
        for (int i = 0; i < NW; i++)
            if (wv[i]) word[i] = rank[i];
    endfunction

    function automatic logic [3:0] shortest_slot(bit skip_cur);
        int best;
        best = NT;
        for (int i = 0; i < NT; i++) begin
            if (!rv[i] || (skip_cur && 4'(i) == cur)) continue;
            if (best >= NT || rbud[i] < rbud[best] ||
                (rbud[i] == rbud[best] && rid[i] < rid[best]))
                best = i;
        end
        return best < NT ? 4'(best) : cur;
    endfunction

    function automatic void push_event(logic [1:0] k, logic [15:0] n, logic [7:0] s,
                                       logic [31:0] e, logic l);
        t_sched_event ev;
        ev.kind = k;
        ev.num = n;
        ev.slice = s;
        ev.elapsed = e;
        ev.last = l;
        expected_events.push_back(ev);
    endfunction

    function automatic void push_dispatch();
        logic [BUD_W-1:0] b;
        b = rbud[cur];
        push_event(KIND_DISPATCH, rid[cur], b < quant_q ? b[7:0] : quant_q, '0, 1'b1);
    endfunction

    // work out the results of one request
    function automatic void predict_request(logic [2:0] cmd, logic [9:0] q,
                                            logic [31:0] rel, logic [7:0] ticks);
        int cnt;
        int w;
        logic [3:0] old, p;
        if (cmd == CMD_REGISTER) begin
            cnt = 0;
            w = NW;
            for (int i = 0; i < NW; i++) if (wv[i]) cnt++;
            for (int i = NW - 1; i >= 0; i--) if (!wv[i]) w = i;
            if (w >= NW) begin
                push_event(KIND_FULL, '0, '0, '0, 1'b1);
                return;
            end
            wv[w] = 1'b1;
            wbud[w] = q;
            wrel[w] = rel;
            word[w] = 16'(cnt);
            return;
        end
        if (cmd == CMD_START) begin
            if (running) return;
            release_due();
            if (!rv[cur]) begin
                push_event(KIND_DONE, '0, '0, '0, 1'b1);
                return;
            end
            running = 1'b1;
            if (pol_q == POL_SJF || pol_q == POL_PSJF) cur = shortest_slot(0);
            push_dispatch();
            return;
        end
        if (cmd > CMD_FINISH || !running || !rv[cur]) return;
        if (cmd != CMD_FINISH) begin
            rbud[cur] = rbud[cur] > ticks ? rbud[cur] - ticks : '0;
            if (rbud[cur] != 0) begin
                now_ticks = now_ticks + ticks;
                release_due();
                case (pol_q)
                    POL_RR: begin
                        if (cmd == CMD_YIELD || rr_cnt >= rr_q) begin
                            rr_cnt = 0;
                            cur = rnext[cur];
                        end
                        rr_cnt = rr_cnt + 1'b1;
                    end
                    POL_FCFS: ;
                    POL_SJF: if (cmd == CMD_YIELD) cur = shortest_slot(0);
                    POL_PSJF: cur = shortest_slot(0);
                    default: cur = rnext[cur];
                endcase
                push_dispatch();
                return;
            end
        end
        // retire the running thread
        now_ticks = now_ticks + ticks;
        release_due();
        old = cur;
        push_event(KIND_EXIT, rid[old], '0, now_ticks - rent[old], 1'b0);
        if (rnext[old] == old) begin
            rv[old] = 1'b0;
            running = 1'b0;
            push_event(KIND_DONE, '0, '0, '0, 1'b1);
            return;
        end
        if (pol_q == POL_RR) begin
            rr_cnt = 1;
            cur = rnext[cur];
        end else if (pol_q == POL_SJF || pol_q == POL_PSJF) begin
            cur = shortest_slot(1);
        end else begin
            cur = rnext[cur];
        end
        p = ring_pred(old);
        rnext[p] = rnext[old];
        rv[old] = 1'b0;
        push_dispatch();
    endfunction

    // receiver: own stall pattern, calm stretches and long hold-offs
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            int mode;
            int span;
            mode = $urandom_range(0, 2);
            span = $urandom_range(10, 80);
            if (hold_off) begin
                rsp_if.ready = 1'b0;
                repeat (400) @(negedge i_clk);
                hold_off = 0;
            end
            repeat (span) begin
                @(negedge i_clk);
                case (mode)
                    0: rsp_if.ready = 1'b1;
                    1: rsp_if.ready = ($urandom_range(0, 3) != 0);
                    default: rsp_if.ready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // result check
    always @(posedge i_clk) begin
        if (rsp_if.valid && rsp_if.ready) begin
            if (expected_events.size() == 0) begin
                $error("unexpected result kind %0d", rsp_if.kind);
                errors++;
            end else begin
                t_sched_event ev;
                ev = expected_events.pop_front();
                if (rsp_if.kind !== ev.kind) begin
                    $error("kind: expected %0d got %0d", ev.kind, rsp_if.kind);
                    errors++;
                end
                if (rsp_if.thread_number !== ev.num) begin
                    $error("thread_number: expected %0d got %0d", ev.num,
                           rsp_if.thread_number);
                    errors++;
                end
                if (rsp_if.slice !== ev.slice) begin
                    $error("slice: expected %0d got %0d", ev.slice, rsp_if.slice);
                    errors++;
                end
                if (rsp_if.elapsed !== ev.elapsed) begin
                    $error("elapsed: expected %0d got %0d", ev.elapsed, rsp_if.elapsed);
                    errors++;
                end
                if (rsp_if.last !== ev.last) begin
                    $error("last: expected %0d got %0d", ev.last, rsp_if.last);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no traffic
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("thread_scheduler_multi_policy_tb failed");
            $finish;
        end
    end

    // sender burst state
    int burst_left = 0;

    task automatic send_request(logic [2:0] cmd, logic [9:0] q, logic [31:0] rel,
                                logic [7:0] ticks);
        if (burst_left == 0) begin
            @(negedge i_clk);
            req_if.valid = 1'b0;
            repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20)) @(negedge i_clk);
            burst_left = $urandom_range(1, 30);
        end else begin
            @(negedge i_clk);
        end
        burst_left--;
        req_if.valid = 1'b1;
        req_if.command = cmd;
        req_if.work_quanta = q;
        req_if.release_time = rel;
        req_if.ticks_used = ticks;
        do @(posedge i_clk); while (!req_if.ready);
        predict_request(cmd, q, rel, ticks);
    endtask

    task automatic drain();
        @(negedge i_clk);
        req_if.valid = 1'b0;
        burst_left = 0;
        wait (expected_events.size() == 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_POLICY: pol_q = data[POL_W-1:0];
            CFG_QUANTUM: quant_q = data;
            CFG_RR: rr_q = data[RR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic test_directed();
        // empty ring, commands while stopped, undefined commands
        send_request(CMD_START, 0, 0, 0);
        send_request(CMD_EXPIRE, 0, 0, 10);
        send_request(CMD_FINISH, 0, 0, 0);
        send_request(3'd7, 10'h3FF, 32'hFFFF_FFFF, 8'hFF);
        // one thread that never becomes due
        send_request(CMD_REGISTER, 10'h3FF, 32'hFFFF_FFFF, 0);
        send_request(CMD_START, 0, 0, 0);
        // fill the waiting table, then overflow it
        for (int i = 0; i < 15; i++) send_request(CMD_REGISTER, 10'(i % 4), 0, 0);
        send_request(CMD_REGISTER, 10'h3FF, 0, 8'hFF);
        send_request(CMD_START, 0, 0, 0);
        send_request(CMD_START, 0, 0, 0);
        send_request(CMD_EXPIRE, 0, 0, 8'd3);
        send_request(CMD_YIELD, 0, 0, 8'hFF);
        send_request(3'd5, 0, 0, 0);
        send_request(3'd6, 0, 0, 0);
        send_request(CMD_FINISH, 0, 0, 8'hFF);
        // retire everything still runnable
        while (running) send_request(CMD_FINISH, 0, 0, 8'd1);
        drain();
    endtask

    task automatic test_policy(logic [7:0] pol, logic [7:0] qt, logic [7:0] rr, int n,
                               bit squeeze);
        int waiting;
        int r;
        logic [2:0] cmd;
        logic [9:0] q;
        logic [31:0] rel;
        logic [7:0] ticks;
        write_reg(CFG_POLICY, pol);
        write_reg(CFG_QUANTUM, qt);
        write_reg(CFG_RR, rr);
        for (int k = 0; k < n; k++) begin
            if (squeeze && k == n / 2) hold_off = 1;
            waiting = 0;
            for (int i = 0; i < NW; i++) if (wv[i]) waiting++;
            r = $urandom_range(0, 99);
            q = ($urandom_range(0, 19) == 0) ? 10'($urandom) : 10'($urandom_range(0, 4));
            rel = now_ticks + $urandom_range(0, 400);
            ticks = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, qt));
            if (r < 30 && (waiting < 14 || r < 3)) cmd = CMD_REGISTER;
            else if (!running) cmd = CMD_START;
            else if (r < 60) cmd = CMD_EXPIRE;
            else if (r < 80) cmd = CMD_YIELD;
            else if (r < 95) cmd = CMD_FINISH;
            else cmd = 3'($urandom_range(1, 7));
            send_request(cmd, q, rel, ticks);
        end
        drain();
    endtask

    initial begin
        pol_q = POLICY_RST;
        quant_q = QUANTUM_RST;
        rr_q = RR_RST;
        for (int i = 0; i < NT; i++) begin
            rv[i] = 0; rid[i] = 0; rbud[i] = 0; rent[i] = 0; rnext[i] = 0;
        end
        for (int i = 0; i < NW; i++) begin
            wv[i] = 0; wbud[i] = 0; wrel[i] = 0; word[i] = 0;
        end
        cur = 0;
        now_ticks = 0;
        next_id = 1;
        running = 0;
        rr_cnt = 1;
        req_if.valid = 1'b0;
        req_if.command = '0;
        req_if.work_quanta = '0;
        req_if.release_time = '0;
        req_if.ticks_used = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (SETTLE) @(negedge i_clk);

        test_directed();
        test_policy({5'd0, POL_RING}, 8'd5, 8'd3, 170, 1);
        test_policy({5'd0, POL_RR}, 8'd1, 8'd1, 170, 0);
        test_policy({5'd0, POL_RR}, 8'd255, 8'd15, 170, 1);
        test_policy({5'd0, POL_FCFS}, 8'd7, 8'd2, 170, 0);
        test_policy({5'd0, POL_SJF}, 8'd4, 8'd9, 170, 0);
        test_policy({5'd0, POL_PSJF}, 8'd255, 8'd1, 170, 1);
        test_policy(8'd5, 8'd1, 8'd15, 130, 0);
        test_policy(8'd7, 8'd6, 8'd4, 130, 0);
        test_policy({5'd0, POL_RR}, 8'($urandom_range(1, 255)), 8'($urandom_range(1, 15)),
                    150, 0);

        if (errors == 0) begin
            $display("thread_scheduler_multi_policy_tb passed");
        end else begin
            $display("thread_scheduler_multi_policy_tb failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ----- filelist.f -----
design/tsched_pkg.sv
design/tsched_if.sv
design/tsched_alu.sv
design/thread_scheduler_multi_policy.sv
tb/thread_scheduler_multi_policy_tb.sv
